FILE: hdl/tcp_port_rewrite_flow_counter_assert.svh
// assertion macros shared by the rtl files
`ifndef TCP_PORT_REWRITE_FLOW_COUNTER_ASSERT_SVH
`define TCP_PORT_REWRITE_FLOW_COUNTER_ASSERT_SVH
`ifndef SYNTHESIS
`define PRFC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define PRFC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PRFC_ASSERT(lbl, clk, rst, prop)
`define PRFC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: hdl/prfc_pkg.sv
// ----------------------------------------------------------------------------
// prfc_pkg
// types and constants of the tcp port rewriter with flow counter
// ----------------------------------------------------------------------------
package prfc_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 1024;
  localparam logic [15:0] PUB_PORT_RST = 16'd8000;
  localparam logic [15:0] SRV_PORT_RST = 16'd8001;

  localparam logic [1:0] STATUS_NONE   = 2'd0;
  localparam logic [1:0] STATUS_INCR   = 2'd1;
  localparam logic [1:0] STATUS_INSERT = 2'd2;
  localparam logic [1:0] STATUS_FULL   = 2'd3;

  localparam logic REG_LISTEN  = 1'b0;
  localparam logic REG_BACKEND = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_last;
    logic [63:0] flow_count;
    logic [1:0]  flow_status;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [95:0] key;
  } flow_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] count;
    logic [1:0]  status;
  } flow_rsp_t;

endpackage

FILE: hdl/prfc_flow_table.sv
// ----------------------------------------------------------------------------
// prfc_flow_table
// flow key and counter memories, linear search over the filled entries
// ----------------------------------------------------------------------------
`include "tcp_port_rewrite_flow_counter_assert.svh"
module prfc_flow_table #(
  parameter int unsigned ENTRIES = prfc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  prfc_pkg::flow_req_t req,
  output prfc_pkg::flow_rsp_t rsp
);
  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned FW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {T_IDLE, T_READ, T_CMP} tstate_t;

  logic [95:0] key_mem [ENTRIES];
  logic [63:0] cnt_mem [ENTRIES];

  tstate_t     state;
  logic [FW-1:0] addr;
  logic [FW-1:0] fill;
  logic [95:0] key_q;
  logic [95:0] rd_key;
  logic [63:0] rd_cnt;
  logic        done;
  logic [63:0] count;
  logic [1:0]  status;

  logic          wr_key_en;
  logic          wr_cnt_en;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_cnt;
  logic          at_end;
  logic          has_room;
  logic          hit;

  assign at_end   = (addr == fill);
  assign has_room = (fill < FW'(ENTRIES));
  assign hit      = (rd_key == key_q);

  always_comb begin
    wr_key_en = 1'b0;
    wr_cnt_en = 1'b0;
    wr_addr   = addr[AW-1:0];
    wr_cnt    = rd_cnt + 64'd1;
    if (state == T_READ && at_end && has_room) begin
      wr_key_en = 1'b1;
      wr_cnt_en = 1'b1;
      wr_addr   = fill[AW-1:0];
      wr_cnt    = 64'd1;
    end else if (state == T_CMP && hit) begin
      wr_cnt_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_key_en) key_mem[wr_addr] <= key_q;
    if (wr_cnt_en) cnt_mem[wr_addr] <= wr_cnt;
    rd_key <= key_mem[addr[AW-1:0]];
    rd_cnt <= cnt_mem[addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      addr  <= '0;
      fill  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        T_IDLE: begin
          if (req.valid) begin
            key_q <= req.key;
            addr  <= '0;
            state <= T_READ;
          end
        end
        T_READ: begin
          if (at_end) begin
            done  <= 1'b1;
            state <= T_IDLE;
            if (has_room) begin
              fill   <= fill + FW'(1);
              count  <= 64'd1;
              status <= prfc_pkg::STATUS_INSERT;
            end else begin
              count  <= 64'd0;
              status <= prfc_pkg::STATUS_FULL;
            end
          end else begin
            state <= T_CMP;
          end
        end
        T_CMP: begin
          if (hit) begin
            done   <= 1'b1;
            count  <= wr_cnt;
            status <= prfc_pkg::STATUS_INCR;
            state  <= T_IDLE;
          end else begin
            addr  <= addr + FW'(1);
            state <= T_READ;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  assign rsp.busy   = (state != T_IDLE);
  assign rsp.done   = done;
  assign rsp.count  = count;
  assign rsp.status = status;

  `PRFC_ASSERT(a_fill_bound, clk, rst, fill <= FW'(ENTRIES))
  `PRFC_ASSERT(a_addr_bound, clk, rst, addr <= fill)
  `PRFC_ASSERT(a_fill_step, clk, rst, (fill != $past(fill)) |-> $past(state == T_READ))
endmodule

FILE: hdl/tcp_port_rewrite_flow_counter.sv
// ----------------------------------------------------------------------------
// tcp_port_rewrite_flow_counter
// rewrites tcp ports of ipv4 frames and counts rewritten flows per key
// ----------------------------------------------------------------------------
//  channel | direction | handshake       | payload
//  in      | input     | in_valid/stall  | in_byte, in_last
//  out     | output    | out_valid/stall | out_byte, out_last, flow_count, flow_status
//  apb     | input     | psel/penable    | pub_port @0x0, srv_port @0x4
//
// one byte per cycle outside the tcp header while the output is not stalled;
// bytes 34..53 are held and leave one per cycle after byte 53 while the output
// is not stalled, input stalled while they drain. a counted frame also waits for the
// flow search over the filled entries, via the single read port of the flow memories.
// synchronous reset clears control state and the fill count; no clearing pass.
// a waiting output transfer holds the output register and stalls the input.
module tcp_port_rewrite_flow_counter #(
  parameter int unsigned TABLE_ENTRIES = prfc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  prfc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output prfc_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  `include "tcp_port_rewrite_flow_counter_assert.svh"

  typedef enum logic [1:0] {S_RUN, S_WAIT, S_DRAIN} state_t;

  state_t      state;
  logic [15:0] pub_port;
  logic [15:0] srv_port;
  logic [5:0]  pos;
  logic        hdr_ok;
  logic [31:0] saddr;
  logic [31:0] daddr;
  logic [1:0]  fstatus;
  logic [63:0] fcount;
  logic [7:0]  hold [20];
  logic [4:0]  dcnt;
  logic [4:0]  dend;
  logic        frame_last;
  logic        ovalid;
  prfc_pkg::out_item_t opay;

  prfc_pkg::flow_req_t freq;
  prfc_pkg::flow_rsp_t frsp;

  logic        o_free;
  logic        o_push;
  logic        accept;
  logic [15:0] sport;
  logic [15:0] dport;
  logic        dmatch;
  logic        smatch;
  logic [4:0]  idx;

  assign o_free   = !ovalid || !out_stall;
  assign in_stall = !(state == S_RUN && o_free);
  assign accept   = in_valid && !in_stall;
  assign o_push   = (state == S_RUN && accept && (pos < 6'd34 || pos == 6'd54)) ||
                    (state == S_DRAIN);
  assign idx      = 5'(pos - 6'd34);
  assign sport    = {hold[0], hold[1]};
  assign dport    = {hold[2], hold[3]};
  assign dmatch   = (dport == pub_port);
  assign smatch   = (sport == srv_port);

  // flow key uses the ports after rewriting
  always_comb begin
    freq.valid = accept && pos == 6'd53 && hdr_ok && (dmatch || smatch);
    if (dmatch) freq.key = {saddr, daddr, sport, srv_port};
    else        freq.key = {saddr, daddr, pub_port, dport};
  end

  prfc_flow_table #(.ENTRIES(TABLE_ENTRIES)) u_table (
    .clk (clk),
    .rst (rst),
    .req (freq),
    .rsp (frsp)
  );

  assign pready = 1'b1;
  assign prdata = (paddr[2] == prfc_pkg::REG_BACKEND) ? {16'd0, srv_port}
                                                      : {16'd0, pub_port};

  always_ff @(posedge clk) begin
    if (rst) begin
      pub_port <= prfc_pkg::PUB_PORT_RST;
      srv_port <= prfc_pkg::SRV_PORT_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == prfc_pkg::REG_BACKEND) srv_port <= pwdata[15:0];
      else                                   pub_port <= pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_RUN;
      pos        <= '0;
      hdr_ok     <= 1'b1;
      saddr      <= '0;
      daddr      <= '0;
      fstatus    <= prfc_pkg::STATUS_NONE;
      fcount     <= '0;
      dcnt       <= '0;
      dend       <= '0;
      frame_last <= 1'b0;
      ovalid     <= 1'b0;
    end else begin
      if (o_free) ovalid <= o_push;
      unique case (state)
        S_RUN: begin
          if (accept) begin
            if (pos < 6'd34 || pos == 6'd54) begin
              opay.out_byte    <= in_data.in_byte;
              opay.out_last    <= in_data.in_last;
              opay.flow_count  <= in_data.in_last ? fcount : 64'd0;
              opay.flow_status <= in_data.in_last ? fstatus : prfc_pkg::STATUS_NONE;
              if (in_data.in_last) begin
                fstatus <= prfc_pkg::STATUS_NONE;
                fcount  <= '0;
              end
            end else begin
              hold[idx] <= in_data.in_byte;
              if (pos == 6'd53 || in_data.in_last) begin
                dcnt       <= '0;
                dend       <= idx;
                frame_last <= in_data.in_last;
                state      <= freq.valid ? S_WAIT : S_DRAIN;
              end
              if (pos == 6'd53 && hdr_ok) begin
                if (dmatch) begin
                  hold[2] <= srv_port[15:8];
                  hold[3] <= srv_port[7:0];
                end else if (smatch) begin
                  hold[0] <= pub_port[15:8];
                  hold[1] <= pub_port[7:0];
                end
              end
            end
            if (in_data.in_last) begin
              pos    <= '0;
              hdr_ok <= 1'b1;
              saddr  <= '0;
              daddr  <= '0;
            end else begin
              if ((pos == 6'd12 && in_data.in_byte != 8'h08) ||
                  (pos == 6'd13 && in_data.in_byte != 8'h00) ||
                  (pos == 6'd23 && in_data.in_byte != 8'h06))
                hdr_ok <= 1'b0;
              if (pos >= 6'd26 && pos <= 6'd29) saddr <= {saddr[23:0], in_data.in_byte};
              if (pos >= 6'd30 && pos <= 6'd33) daddr <= {daddr[23:0], in_data.in_byte};
              if (pos < 6'd54) pos <= pos + 6'd1;
            end
          end
        end
        S_WAIT: begin
          if (frsp.done) begin
            fcount  <= frsp.count;
            fstatus <= frsp.status;
            state   <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (o_free) begin
            opay.out_byte    <= hold[dcnt];
            opay.out_last    <= frame_last && dcnt == dend;
            opay.flow_count  <= (frame_last && dcnt == dend) ? fcount : 64'd0;
            opay.flow_status <= (frame_last && dcnt == dend) ? fstatus
                                                             : prfc_pkg::STATUS_NONE;
            if (dcnt == dend) begin
              state <= S_RUN;
              if (frame_last) begin
                fstatus <= prfc_pkg::STATUS_NONE;
                fcount  <= '0;
              end
            end else begin
              dcnt <= dcnt + 5'd1;
            end
          end
        end
        default: state <= S_RUN;
      endcase
    end
  end

  assign out_valid = ovalid;
  assign out_data  = opay;

  `PRFC_ASSERT(a_req_idle, clk, rst, freq.valid |-> !frsp.busy)
  `PRFC_ASSERT(a_wait_hold, clk, rst, (state == S_WAIT && !frsp.done) |=> state == S_WAIT)
  `PRFC_ASSERT(a_pos_bound, clk, rst, pos <= 6'd54)
  `PRFC_ASSERT(a_drain_bound, clk, rst, state == S_DRAIN |-> dcnt <= dend)
endmodule
